FILE: hw/rtl/otg_pkg.sv
package otg_pkg;

   // Default tape width limit, used by the top level parameter.
   localparam int MAX_COLUMNS_DEF = 30;

   // Field widths
   localparam int ANGLE_W   = 13;
   localparam int ROW_W     = 4;
   localparam int OUT_ROW_W = 5;
   localparam int COL_W     = 5;
   localparam int GLYPH_W   = 8;
   localparam int RING_W    = 6;
   localparam int Q30_W     = 8;
   localparam int CENTER_W  = 11;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   // Angle arithmetic, sixteenths of a degree
   localparam logic [ANGLE_W-1:0] FULL_TURN  = 13'd5760;
   localparam logic [ANGLE_W-1:0] HALF_TURN  = 13'd2880;
   localparam logic [7:0]         STEP_ANGLE = 8'd120;
   localparam logic [RING_W-1:0]  RING_LAST  = 6'd47;

   // x/30 as (x * 8739) >> 18, exact for x below 10082
   localparam logic [13:0] DIV30_MUL   = 14'd8739;
   localparam int          DIV30_SHIFT = 18;
   localparam int          PROD_W      = 27;

   // Register reset and clamp values
   localparam logic [COL_W-1:0] TAPE_RESET  = 5'd12;
   localparam logic [COL_W-1:0] MIN_COLUMNS = 5'd3;

   // Font codes
   localparam logic [GLYPH_W-1:0] GLYPH_BLANK   = 8'h00;
   localparam logic [GLYPH_W-1:0] GLYPH_NORTH   = 8'h18;
   localparam logic [GLYPH_W-1:0] GLYPH_EAST    = 8'h0F;
   localparam logic [GLYPH_W-1:0] GLYPH_SOUTH   = 8'h1D;
   localparam logic [GLYPH_W-1:0] GLYPH_WEST    = 8'h21;
   localparam logic [GLYPH_W-1:0] GLYPH_MAJ_P0  = 8'hD2;
   localparam logic [GLYPH_W-1:0] GLYPH_MAJ_P1  = 8'hD4;
   localparam logic [GLYPH_W-1:0] GLYPH_MAJ_P2  = 8'hD3;
   localparam logic [GLYPH_W-1:0] GLYPH_MAJ_P3  = 8'hD5;
   localparam logic [GLYPH_W-1:0] GLYPH_MIN_EVN = 8'hD0;
   localparam logic [GLYPH_W-1:0] GLYPH_MIN_ODD = 8'hD1;

   // Ring positions of the cardinal letters
   localparam logic [RING_W-1:0] RING_NORTH = 6'd0;
   localparam logic [RING_W-1:0] RING_EAST  = 6'd12;
   localparam logic [RING_W-1:0] RING_SOUTH = 6'd24;
   localparam logic [RING_W-1:0] RING_WEST  = 6'd36;

   typedef enum logic [2:0] {
      REG_BASE_ROW    = 3'd0,
      REG_BASE_COLUMN = 3'd1,
      REG_TAPE_COLS   = 3'd2,
      REG_RIGHT_ARROW = 3'd3,
      REG_LEFT_ARROW  = 3'd4,
      REG_UP_ARROW    = 3'd5
   } reg_idx_type;

   // Register values plus a few figures derived from them
   typedef struct packed {
      logic [ROW_W-1:0]    base_row;
      logic [COL_W-1:0]    base_column;
      logic [COL_W-1:0]    tape_columns;
      logic [GLYPH_W-1:0]  right_arrow_glyph;
      logic [GLYPH_W-1:0]  left_arrow_glyph;
      logic [GLYPH_W-1:0]  up_arrow_glyph;
      logic [COL_W-1:0]    width;          // clamped tape width
      logic [CENTER_W-1:0] center_angle;   // center column times one step
      logic [RING_W-1:0]   last_cell_idx;  // cells per item minus one
   } otg_cfg_type;

   // One tape update handed from the angle pipeline to the cell emitter
   typedef struct packed {
      logic              right;
      logic [1:0]        phase;
      logic [RING_W-1:0] ie;       // ring position of the leftmost inner column
      logic [RING_W-1:0] ie_mark;  // same, offset by the bearing marker
   } otg_task_type;

   function automatic logic [Q30_W-1:0] div30(input logic [ANGLE_W-1:0] x);
      logic [PROD_W-1:0] p;
      p = PROD_W'(x) * PROD_W'(DIV30_MUL);
      return p[DIV30_SHIFT +: Q30_W];
   endfunction

   function automatic logic [GLYPH_W-1:0] card_glyph(input logic [RING_W-1:0] ie);
      logic [GLYPH_W-1:0] g;
      g = GLYPH_BLANK;
      if (ie == RING_NORTH) g = GLYPH_NORTH;
      if (ie == RING_EAST)  g = GLYPH_EAST;
      if (ie == RING_SOUTH) g = GLYPH_SOUTH;
      if (ie == RING_WEST)  g = GLYPH_WEST;
      return g;
   endfunction

   // True on ring positions that are multiples of three
   function automatic logic tick_major(input logic [RING_W-1:0] ie);
      logic r;
      r = 1'b0;
      for (int k = 0; k < 16; k++) begin
         if (ie == RING_W'(3 * k)) r = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [GLYPH_W-1:0] top_glyph(input logic major,
                                                   input logic [1:0] phase);
      logic [GLYPH_W-1:0] g;
      if (major) begin
         case (phase)
            2'd0:    g = GLYPH_MAJ_P0;
            2'd1:    g = GLYPH_MAJ_P1;
            2'd2:    g = GLYPH_MAJ_P2;
            default: g = GLYPH_MAJ_P3;
         endcase
      end else begin
         g = phase[0] ? GLYPH_MIN_ODD : GLYPH_MIN_EVN;
      end
      return g;
   endfunction

endpackage

FILE: hw/rtl/otg_ifs.sv
interface otg_req_if import otg_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] heading_angle;
   logic [ANGLE_W-1:0] bearing_angle;

   modport source (output valid, output heading_angle, output bearing_angle, input ready);
   modport sink   (input valid, input heading_angle, input bearing_angle, output ready);
endinterface

interface otg_rsp_if import otg_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [OUT_ROW_W-1:0] cell_row;
   logic [COL_W-1:0]     cell_column;
   logic [GLYPH_W-1:0]   glyph_code;
   logic                 last_cell;

   modport source (output valid, output cell_row, output cell_column, output glyph_code,
                   output last_cell, input ready);
   modport sink   (input valid, input cell_row, input cell_column, input glyph_code,
                   input last_cell, output ready);
endinterface

FILE: hw/rtl/osd_compass_tape_glyphs_core.sv
// Compass tape cell generator. Each item carries a heading and a target
// bearing in sixteenths of a degree; the block answers with the character
// cells of a two-row tape: first the end cell with the turn arrow (on the
// side of the shorter turn), then the blank opposite end cell, then for
// every inner column the lower cell (bearing marker, N/E/S/W letter or
// blank) followed by the upper tick cell. last_cell flags the final cell.
// An item with a clamped width of W columns yields 2*W-2 cells, one per
// clock while the result side takes them; the cell emitter walking the
// columns takes up the next item as it hands over the last cell of the
// one before. An item passes the four-stage angle pipeline and the
// emitter's item slot before its first cell reaches the output register;
// the pipeline keeps accepting items while the emitter is still busy with
// an earlier one. Registers must be written through the csr port only
// while no item is in flight; the block itself does not enforce this.
module osd_compass_tape_glyphs_core import otg_pkg::*; #(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   otg_req_if.sink           req_bus,
   otg_rsp_if.source         rsp_bus,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   otg_cfg_type  cfg;
   otg_task_type task_data;
   logic         task_valid;
   logic         task_ready;

   // register file; also clamps the width and precomputes the tape center
   otg_csr #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // angle pipeline: reduce, turn side / offsets, divide by 30, ring positions
   otg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .heading    (req_bus.heading_angle),
      .bearing    (req_bus.bearing_angle),
      .task_valid (task_valid),
      .task_ready (task_ready),
      .task_out   (task_data)
   );

   // per-cell sequencer with the output register
   otg_emit #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .task_valid  (task_valid),
      .task_ready  (task_ready),
      .task_in     (task_data),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .cell_row    (rsp_bus.cell_row),
      .cell_column (rsp_bus.cell_column),
      .glyph_code  (rsp_bus.glyph_code),
      .last_cell   (rsp_bus.last_cell)
   );

endmodule

FILE: hw/rtl/otg_csr.sv
module otg_csr import otg_pkg::*; #(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output otg_cfg_type       cfg
);

   logic [ROW_W-1:0]   base_row_ff, base_row_in;
   logic [COL_W-1:0]   base_col_ff, base_col_in;
   logic [COL_W-1:0]   tape_cols_ff, tape_cols_in;
   logic [GLYPH_W-1:0] right_ff, right_in;
   logic [GLYPH_W-1:0] left_ff, left_in;
   logic [GLYPH_W-1:0] up_ff, up_in;
   logic               wr_en;
   reg_idx_type        idx;
   logic [COL_W-1:0]   width;
   logic [COL_W-1:0]   inner;
   logic [3:0]         center;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_idx_type'(paddr[4:2]);

   always_comb begin
      base_row_in  = base_row_ff;
      base_col_in  = base_col_ff;
      tape_cols_in = tape_cols_ff;
      right_in     = right_ff;
      left_in      = left_ff;
      up_in        = up_ff;
      if (wr_en) begin
         unique case (idx)
            REG_BASE_ROW:    base_row_in  = pwdata[ROW_W-1:0];
            REG_BASE_COLUMN: base_col_in  = pwdata[COL_W-1:0];
            REG_TAPE_COLS:   tape_cols_in = pwdata[COL_W-1:0];
            REG_RIGHT_ARROW: right_in     = pwdata[GLYPH_W-1:0];
            REG_LEFT_ARROW:  left_in      = pwdata[GLYPH_W-1:0];
            REG_UP_ARROW:    up_in        = pwdata[GLYPH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_row_ff  <= '0;
         base_col_ff  <= '0;
         tape_cols_ff <= TAPE_RESET;
         right_ff     <= '0;
         left_ff      <= '0;
         up_ff        <= '0;
      end else begin
         base_row_ff  <= base_row_in;
         base_col_ff  <= base_col_in;
         tape_cols_ff <= tape_cols_in;
         right_ff     <= right_in;
         left_ff      <= left_in;
         up_ff        <= up_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_BASE_ROW:    prdata = DATA_W'(base_row_ff);
         REG_BASE_COLUMN: prdata = DATA_W'(base_col_ff);
         REG_TAPE_COLS:   prdata = DATA_W'(tape_cols_ff);
         REG_RIGHT_ARROW: prdata = DATA_W'(right_ff);
         REG_LEFT_ARROW:  prdata = DATA_W'(left_ff);
         REG_UP_ARROW:    prdata = DATA_W'(up_ff);
         default:         prdata = '0;
      endcase
   end

   // Clamp width to 3..MAX_COLUMNS; derived figures are static while idle
   always_comb begin
      if (tape_cols_ff < MIN_COLUMNS) begin
         width = MIN_COLUMNS;
      end else if ({1'b0, tape_cols_ff} > 6'(MAX_COLUMNS)) begin
         width = COL_W'(MAX_COLUMNS);
      end else begin
         width = tape_cols_ff;
      end
      inner  = width - 5'd2;
      center = inner[4:1];
      cfg.base_row          = base_row_ff;
      cfg.base_column       = base_col_ff;
      cfg.tape_columns      = tape_cols_ff;
      cfg.right_arrow_glyph = right_ff;
      cfg.left_arrow_glyph  = left_ff;
      cfg.up_arrow_glyph    = up_ff;
      cfg.width             = width;
      cfg.center_angle      = CENTER_W'(center) * CENTER_W'(STEP_ANGLE);
      cfg.last_cell_idx     = {width, 1'b0} - 6'd3;
   end

endmodule

FILE: hw/rtl/otg_front.sv
module otg_front import otg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  otg_cfg_type        cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [ANGLE_W-1:0] heading,
   input  logic [ANGLE_W-1:0] bearing,
   output logic               task_valid,
   input  logic               task_ready,
   output otg_task_type       task_out
);

   // stage 1: angles reduced to one turn
   logic               v1_ff, v1_in;
   logic [ANGLE_W-1:0] h1_ff, h1_in, b1_ff, b1_in;
   // stage 2: turn side, tape offset and bearing complement
   logic               v2_ff, v2_in;
   logic               right2_ff, right2_in;
   logic [ANGLE_W-1:0] hs2_ff, hs2_in, bs2_ff, bs2_in;
   // stage 3: quotients by 30
   logic               v3_ff, v3_in;
   logic               right3_ff, right3_in;
   logic [Q30_W-1:0]   qh3_ff, qh3_in, qb3_ff, qb3_in;
   // stage 4: ring positions
   logic               v4_ff, v4_in;
   otg_task_type       t4_ff, t4_in;

   logic rdy1, rdy2, rdy3, rdy4;

   logic signed [ANGLE_W:0] diff;
   logic signed [ANGLE_W:0] hs_raw;
   logic [RING_W-1:0]       whole, marker, ie0;
   logic [RING_W:0]         mark_sum;

   assign rdy4     = !v4_ff || task_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      v1_in = v1_ff;
      h1_in = h1_ff;
      b1_in = b1_ff;
      if (rdy1) begin
         v1_in = in_valid;
         h1_in = (heading >= FULL_TURN) ? heading - FULL_TURN : heading;
         b1_in = (bearing >= FULL_TURN) ? bearing - FULL_TURN : bearing;
      end
   end

   always_comb begin
      diff   = $signed({1'b0, b1_ff}) - $signed({1'b0, h1_ff});
      hs_raw = $signed((ANGLE_W+1)'(cfg.center_angle)) - $signed({1'b0, h1_ff});
      v2_in     = v2_ff;
      right2_in = right2_ff;
      hs2_in    = hs2_ff;
      bs2_in    = bs2_ff;
      if (rdy2) begin
         v2_in = v1_ff;
         // plus half turn is right, minus half turn and zero are left
         right2_in = (diff > 0 && diff <= $signed({1'b0, HALF_TURN})) ||
                     (diff < -$signed({1'b0, HALF_TURN}));
         hs2_in = hs_raw[ANGLE_W] ? ANGLE_W'(hs_raw + $signed({1'b0, FULL_TURN}))
                                  : hs_raw[ANGLE_W-1:0];
         bs2_in = (b1_ff == '0) ? '0 : FULL_TURN - b1_ff;
      end
   end

   always_comb begin
      v3_in     = v3_ff;
      right3_in = right3_ff;
      qh3_in    = qh3_ff;
      qb3_in    = qb3_ff;
      if (rdy3) begin
         v3_in     = v2_ff;
         right3_in = right2_ff;
         qh3_in    = div30(hs2_ff);
         qb3_in    = div30(bs2_ff);
      end
   end

   always_comb begin
      whole    = qh3_ff[Q30_W-1:2];
      marker   = qb3_ff[Q30_W-1:2];
      ie0      = (whole == '0) ? '0 : RING_LAST + 6'd1 - whole;
      mark_sum = {1'b0, ie0} + {1'b0, marker};
      v4_in    = v4_ff;
      t4_in    = t4_ff;
      if (rdy4) begin
         v4_in       = v3_ff;
         t4_in.right = right3_ff;
         t4_in.phase = qh3_ff[1:0];
         t4_in.ie    = ie0;
         t4_in.ie_mark = (mark_sum > {1'b0, RING_LAST}) ?
                         RING_W'(mark_sum - {1'b0, RING_LAST} - 7'd1) : mark_sum[RING_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      h1_ff     <= h1_in;
      b1_ff     <= b1_in;
      right2_ff <= right2_in;
      hs2_ff    <= hs2_in;
      bs2_ff    <= bs2_in;
      right3_ff <= right3_in;
      qh3_ff    <= qh3_in;
      qb3_ff    <= qb3_in;
      t4_ff     <= t4_in;
   end

   assign task_valid = v4_ff;
   assign task_out   = t4_ff;

endmodule

FILE: hw/rtl/otg_emit.sv
module otg_emit import otg_pkg::*; #(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  otg_cfg_type          cfg,
   input  logic                 task_valid,
   output logic                 task_ready,
   input  otg_task_type         task_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUT_ROW_W-1:0] cell_row,
   output logic [COL_W-1:0]     cell_column,
   output logic [GLYPH_W-1:0]   glyph_code,
   output logic                 last_cell
);

   localparam int CNT_W = $clog2(2 * MAX_COLUMNS - 2);

   // item being walked
   logic               slot_v_ff, slot_v_in;
   otg_task_type       slot_ff, slot_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COL_W-1:0]   i_ff, i_in;
   // output register
   logic                 out_v_ff, out_v_in;
   logic [OUT_ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [GLYPH_W-1:0]   glyph_ff, glyph_in;
   logic                 last_ff, last_in;

   logic                 advance, at_last;
   logic [COL_W-1:0]     far_col, in_col;
   logic [OUT_ROW_W-1:0] top_row;

   always_comb begin
      advance    = slot_v_ff && (!out_v_ff || rsp_ready);
      at_last    = cnt_ff == cfg.last_cell_idx[CNT_W-1:0];
      task_ready = !slot_v_ff || (advance && at_last);
      far_col    = cfg.base_column + cfg.width - 5'd1;
      in_col     = cfg.base_column + 5'd1 + i_ff;
      top_row    = {1'b0, cfg.base_row};

      slot_v_in = slot_v_ff;
      slot_in   = slot_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      out_v_in  = out_v_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      glyph_in  = glyph_ff;
      last_in   = last_ff;

      if (advance) begin
         out_v_in = 1'b1;
         last_in  = at_last;
         cnt_in   = cnt_ff + CNT_W'(1);
         if (cnt_ff == '0) begin
            // arrow end cell, on the side of the shorter turn
            row_in   = top_row;
            col_in   = slot_ff.right ? far_col : cfg.base_column;
            glyph_in = slot_ff.right ? cfg.right_arrow_glyph : cfg.left_arrow_glyph;
         end else if (cnt_ff == CNT_W'(1)) begin
            row_in   = top_row;
            col_in   = slot_ff.right ? cfg.base_column : far_col;
            glyph_in = GLYPH_BLANK;
         end else if (!cnt_ff[0]) begin
            // lower row: marker wins over a letter
            row_in   = top_row + 5'd1;
            col_in   = in_col;
            glyph_in = (slot_ff.ie_mark == '0) ? cfg.up_arrow_glyph : card_glyph(slot_ff.ie);
         end else begin
            row_in   = top_row;
            col_in   = in_col;
            glyph_in = top_glyph(tick_major(slot_ff.ie), slot_ff.phase);
            i_in     = i_ff + 5'd1;
            slot_in.ie      = (slot_ff.ie == RING_LAST) ? '0 : slot_ff.ie + 6'd1;
            slot_in.ie_mark = (slot_ff.ie_mark == RING_LAST) ? '0 : slot_ff.ie_mark + 6'd1;
         end
         if (at_last) slot_v_in = 1'b0;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end

      if (task_ready && task_valid) begin
         slot_v_in = 1'b1;
         slot_in   = task_in;
         cnt_in    = '0;
         i_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         slot_v_ff <= slot_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      cnt_ff   <= cnt_in;
      i_ff     <= i_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      glyph_ff <= glyph_in;
      last_ff  <= last_in;
   end

   assign rsp_valid   = out_v_ff;
   assign cell_row    = row_ff;
   assign cell_column = col_ff;
   assign glyph_code  = glyph_ff;
   assign last_cell   = last_ff;

endmodule

FILE: hw/rtl/otg_chk.sv
module otg_chk import otg_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [OUT_ROW_W-1:0] rsp_cell_row,
   input logic [COL_W-1:0]     rsp_cell_column,
   input logic [GLYPH_W-1:0]   rsp_glyph_code,
   input logic                 rsp_last_cell
);

   // nothing left in the output register after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // cell rows stay at or below 16, the highest base row plus one
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cell_row <= 5'd16)
      else $error("cell row out of range");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_cell_row) && $stable(rsp_cell_column) &&
                                  $stable(rsp_glyph_code) && $stable(rsp_last_cell))
      else $error("result changed while stalled");

endmodule

bind osd_compass_tape_glyphs_core otg_chk u_otg_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_cell_row    (rsp_bus.cell_row),
   .rsp_cell_column (rsp_bus.cell_column),
   .rsp_glyph_code  (rsp_bus.glyph_code),
   .rsp_last_cell   (rsp_bus.last_cell)
);

FILE: verif/testbench.sv
module testbench;
   import otg_pkg::*;

   // Angle figures used by the tape predictor, all in sixteenths of a degree.
   localparam int TURN        = int'(FULL_TURN);    // 360 deg
   localparam int HALF        = int'(HALF_TURN);    // 180 deg
   localparam int STEP        = int'(STEP_ANGLE);   // one tape column, 7.5 deg
   localparam int SCALE_ANGLE = 30;                 // one sub-step, a quarter column
   localparam int RING_SIZE   = int'(RING_LAST) + 1; // columns around the full circle
   localparam int MAX_COLS    = MAX_COLUMNS_DEF;
   localparam int HOLD_CYCLES = 600;                // long result-side stall

   typedef struct {
      logic [ANGLE_W-1:0] heading;
      logic [ANGLE_W-1:0] bearing;
   } angle_pair_type;

   typedef struct {
      logic [OUT_ROW_W-1:0] row;
      logic [COL_W-1:0]     col;
      logic [GLYPH_W-1:0]   glyph;
      logic                 last;
   } tape_cell_type;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #10 clock = ~clock;
   end

   // Channels and configuration port
   otg_req_if req_bus ();
   otg_rsp_if rsp_bus ();

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   osd_compass_tape_glyphs_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the registers, updated as each write lands.
   logic [ROW_W-1:0]   cfg_row;
   logic [COL_W-1:0]   cfg_col;
   logic [COL_W-1:0]   cfg_tape;
   logic [GLYPH_W-1:0] cfg_right;
   logic [GLYPH_W-1:0] cfg_left;
   logic [GLYPH_W-1:0] cfg_up;

   angle_pair_type pending_angles[$];   // items waiting for the driver
   tape_cell_type  expected_cells[$];   // cells predicted, oldest first

   int  items_sent     = 0;
   int  items_accepted = 0;
   int  cells_checked  = 0;
   int  settings_run   = 0;
   int  fail_count     = 0;
   int  req_gap_left   = 0;
   int  rsp_wait_left  = 0;
   int  hold_from      = 0;
   bit  hold_go        = 1'b0;
   bit  sink_hold      = 1'b0;  // long stall on the result side
   bit  req_steady     = 1'b0;  // no gaps between items
   bit  rsp_steady     = 1'b0;  // result side always ready
   bit  req_taken      = 1'b0;
   bit  rsp_taken      = 1'b0;

   function automatic void add_cell(input logic [OUT_ROW_W-1:0] row,
                                    input logic [COL_W-1:0] col,
                                    input logic [GLYPH_W-1:0] glyph);
      tape_cell_type c;
      c.row   = row;
      c.col   = col;
      c.glyph = glyph;
      c.last  = 1'b0;
      expected_cells.push_back(c);
   endfunction

   // Works out every cell of one tape update from the current shadow registers.
   function automatic void predict_tape(input logic [ANGLE_W-1:0] heading_in,
                                        input logic [ANGLE_W-1:0] bearing_in);
      int hdg, brg, span, diff, inner, offs, whole, phase, mark, ring, ring_mark, i;
      logic [OUT_ROW_W-1:0] top_row, bottom_row;
      logic [COL_W-1:0]     far_col;
      logic [GLYPH_W-1:0]   lower, upper;

      // angles past a full turn wrap back into range
      hdg = int'(heading_in) % TURN;
      brg = int'(bearing_in) % TURN;
      span = int'(cfg_tape);
      if (span < 3) span = 3;
      if (span > MAX_COLS) span = MAX_COLS;
      top_row    = OUT_ROW_W'(cfg_row);
      bottom_row = top_row + 1'b1;
      far_col    = cfg_col + COL_W'(span - 1);

      // shortest turn: +180 is a right turn, -180 and zero are left turns
      diff = brg - hdg;
      if (diff > HALF) diff -= TURN;
      if (diff < -HALF) diff += TURN;
      if (diff > 0) begin
         add_cell(top_row, far_col, cfg_right);
         add_cell(top_row, cfg_col, GLYPH_BLANK);
      end else begin
         add_cell(top_row, cfg_col, cfg_left);
         add_cell(top_row, far_col, GLYPH_BLANK);
      end

      inner = span - 2;
      offs  = (inner / 2) * STEP - hdg;
      offs  = ((offs % TURN) + TURN) % TURN;
      whole = offs / STEP;
      phase = (offs / SCALE_ANGLE) % 4;
      mark  = (brg == 0) ? 0 : (TURN - brg) / STEP;

      for (i = 0; i < inner; i++) begin
         ring      = (i - whole + RING_SIZE) % RING_SIZE;
         ring_mark = (ring + mark) % RING_SIZE;
         lower     = GLYPH_BLANK;
         if (ring_mark == 0) begin
            lower = cfg_up;
         end else if (ring % 12 == 0) begin
            case ((ring / 12) % 4)
               0:       lower = GLYPH_NORTH;
               1:       lower = GLYPH_EAST;
               2:       lower = GLYPH_SOUTH;
               default: lower = GLYPH_WEST;
            endcase
         end
         if (ring % 3 == 0) begin
            case (phase)
               0:       upper = GLYPH_MAJ_P0;
               1:       upper = GLYPH_MAJ_P1;
               2:       upper = GLYPH_MAJ_P2;
               default: upper = GLYPH_MAJ_P3;
            endcase
         end else begin
            upper = (phase % 2 == 0) ? GLYPH_MIN_EVN : GLYPH_MIN_ODD;
         end
         add_cell(bottom_row, cfg_col + COL_W'(1 + i), lower);
         add_cell(top_row, cfg_col + COL_W'(1 + i), upper);
      end
      expected_cells[expected_cells.size() - 1].last = 1'b1;
   endfunction

   // Mostly in-range angles; some land on the turn-direction edges, some wrap.
   function automatic angle_pair_type random_angles();
      angle_pair_type a;
      int h;
      h = $urandom_range(0, TURN - 1);
      a.heading = ANGLE_W'(h);
      a.bearing = ANGLE_W'($urandom_range(0, TURN - 1));
      case ($urandom_range(0, 19))
         0: a.heading = ANGLE_W'($urandom_range(TURN, 8191));
         1: a.bearing = ANGLE_W'($urandom_range(TURN, 8191));
         2: a.bearing = ANGLE_W'((h + HALF) % TURN);
         3: a.bearing = ANGLE_W'((h + TURN - HALF + $urandom_range(0, 2) - 1) % TURN);
         4: a.bearing = ANGLE_W'(h);
         5: a.bearing = ANGLE_W'((h + $urandom_range(1, 3)) % TURN);
         6: a.bearing = ANGLE_W'($urandom_range(0, 1) ? 0 : $urandom_range(1, 130));
         default: ;
      endcase
      return a;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side. The driver offers the next pending item at the falling edge
   // after a random gap; the monitor predicts at the rising edge of acceptance.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin : feed_angles
      angle_pair_type next;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap_left  <= 0;
      end else if (!req_bus.valid || req_taken) begin
         if (req_gap_left > 0) begin
            req_bus.valid <= 1'b0;
            req_gap_left  <= req_gap_left - 1;
         end else if (pending_angles.size() > 0) begin
            next = pending_angles.pop_front();
            // counted at once so a drain never sees the queue empty with this
            // item neither sent nor accepted
            items_sent++;
            req_bus.valid         <= 1'b1;
            req_bus.heading_angle <= next.heading;
            req_bus.bearing_angle <= next.bearing;
            req_gap_left          <= req_steady ? 0 : $urandom_range(0, 9);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         predict_tape(req_bus.heading_angle, req_bus.bearing_angle);
         items_accepted <= items_accepted + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Result side. ready drops for a random number of cycles after each cell,
   // and stays low for the whole long stall.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin : pace_cells
      int w;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait_left <= 0;
      end else if (sink_hold) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_taken) begin
         w = rsp_steady ? 0 : $urandom_range(0, 9);
         rsp_bus.ready <= (w == 0);
         rsp_wait_left <= (w == 0) ? 0 : w - 1;
      end else if (rsp_wait_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait_left <= rsp_wait_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_cells
      tape_cell_type want;
      rsp_taken <= !reset && rsp_bus.valid && rsp_bus.ready;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         cells_checked <= cells_checked + 1;
         if (expected_cells.size() == 0) begin
            $error("unexpected cell: row %0d column %0d glyph %h",
                   rsp_bus.cell_row, rsp_bus.cell_column, rsp_bus.glyph_code);
            fail_count++;
         end else begin
            want = expected_cells.pop_front();
            if (rsp_bus.cell_row !== want.row) begin
               $error("cell_row: expected %0d, actual %0d", want.row, rsp_bus.cell_row);
               fail_count++;
            end
            if (rsp_bus.cell_column !== want.col) begin
               $error("cell_column: expected %0d, actual %0d", want.col, rsp_bus.cell_column);
               fail_count++;
            end
            if (rsp_bus.glyph_code !== want.glyph) begin
               $error("glyph_code: expected %h, actual %h", want.glyph, rsp_bus.glyph_code);
               fail_count++;
            end
            if (rsp_bus.last_cell !== want.last) begin
               $error("last_cell: expected %0d, actual %0d", want.last, rsp_bus.last_cell);
               fail_count++;
            end
         end
      end
   end

   // Long stall: once armed, waits ten items into the phase and then keeps the
   // result side blocked so the angle pipeline fills and backs up the input.
   initial begin : long_stall
      wait (hold_go);
      wait (items_accepted >= hold_from);
      @(posedge clock);
      sink_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      sink_hold <= 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Configuration writes: setup then access; junk above the field width
   // must be dropped by the register.
   // ---------------------------------------------------------------------------
   task automatic write_reg(input reg_idx_type idx, input logic [DATA_W-1:0] value);
      int w;
      case (idx)
         REG_BASE_ROW:                  w = ROW_W;
         REG_BASE_COLUMN, REG_TAPE_COLS: w = COL_W;
         default:                       w = GLYPH_W;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= (DATA_W'($urandom()) << w) | value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_BASE_ROW:    cfg_row   = value[ROW_W-1:0];
         REG_BASE_COLUMN: cfg_col   = value[COL_W-1:0];
         REG_TAPE_COLS:   cfg_tape  = value[COL_W-1:0];
         REG_RIGHT_ARROW: cfg_right = value[GLYPH_W-1:0];
         REG_LEFT_ARROW:  cfg_left  = value[GLYPH_W-1:0];
         default:         cfg_up    = value[GLYPH_W-1:0];
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Everything offered, accepted and answered; then the pipeline is given
   // time to settle before any register changes.
   task automatic drain();
      wait (pending_angles.size() == 0 && items_sent == items_accepted &&
            expected_cells.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_setting(input int row, input int col, input int tape,
                              input int right, input int left, input int up,
                              input int n_items, input bit steady,
                              input bit pause_mid, input bit hold);
      int k;
      write_reg(REG_BASE_ROW, DATA_W'(row));
      write_reg(REG_BASE_COLUMN, DATA_W'(col));
      write_reg(REG_TAPE_COLS, DATA_W'(tape));
      write_reg(REG_RIGHT_ARROW, DATA_W'(right));
      write_reg(REG_LEFT_ARROW, DATA_W'(left));
      write_reg(REG_UP_ARROW, DATA_W'(up));
      @(posedge clock);
      settings_run++;
      req_steady = steady;
      rsp_steady = steady;
      if (hold) begin
         hold_from = items_accepted + 10;
         hold_go   = 1'b1;
      end
      for (k = 0; k < n_items; k++) begin
         // sender stops halfway until every cell so far is back
         if (pause_mid && k == n_items / 2) begin
            drain();
         end
         pending_angles.push_back(random_angles());
      end
      drain();
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      angle_pair_type a;
      int n;
      int directed[20][2] = '{
         '{0, 0}, '{5759, 5759}, '{0, 2880}, '{2880, 0}, '{0, 2881},
         '{2881, 0}, '{0, 1}, '{1, 0}, '{8191, 8191}, '{5760, 0},
         '{0, 5760}, '{8191, 0}, '{0, 8191}, '{30, 120}, '{60, 240},
         '{90, 4000}, '{120, 5759}, '{4000, 1000}, '{1000, 4000}, '{7000, 6000}
      };
      int warmup[3][2] = '{'{0, 0}, '{0, 2880}, '{5759, 1}};

      req_bus.valid         = 1'b0;
      req_bus.heading_angle = '0;
      req_bus.bearing_angle = '0;
      rsp_bus.ready         = 1'b0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      // shadow registers at their reset values
      cfg_row   = '0;
      cfg_col   = '0;
      cfg_tape  = TAPE_RESET;
      cfg_right = '0;
      cfg_left  = '0;
      cfg_up    = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a few updates on the reset register values
      for (n = 0; n < 3; n++) begin
         a.heading = ANGLE_W'(warmup[n][0]);
         a.bearing = ANGLE_W'(warmup[n][1]);
         pending_angles.push_back(a);
      end
      drain();

      // directed corners on a full-width tape with distinct glyphs
      run_setting(5, 3, 30, 8'h3E, 8'h3C, 8'h1E, 0, 1'b0, 1'b0, 1'b0);
      for (n = 0; n < 20; n++) begin
         a.heading = ANGLE_W'(directed[n][0]);
         a.bearing = ANGLE_W'(directed[n][1]);
         pending_angles.push_back(a);
      end
      drain();

      // extremes: top row and wrapping column with width above the clamp,
      // then the narrowest tape at the origin
      run_setting(15, 31, 31, 8'hFF, 8'h00, 8'hFF, 30, 1'b1, 1'b0, 1'b0);
      run_setting(0, 0, 3, 8'h00, 8'hFF, 8'h00, 25, 1'b0, 1'b0, 1'b0);
      // widest tape while the result side stalls for a long stretch
      run_setting($urandom_range(0, 15), $urandom_range(0, 31), 30,
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  50, 1'b0, 1'b0, 1'b1);
      // widths below the minimum clamp
      run_setting($urandom_range(0, 15), $urandom_range(0, 31), 0,
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  20, 1'b0, 1'b0, 1'b0);
      run_setting($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(1, 2),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  15, 1'b0, 1'b0, 1'b0);
      // sender pauses halfway for a full drain
      run_setting($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  40, 1'b0, 1'b1, 1'b0);
      for (n = 0; n < 3; n++) begin
         run_setting($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), 30, n == 1, 1'b0, 1'b0);
      end

      // final wait, bounded, then quiet time to catch stray cells
      wait (pending_angles.size() == 0 && items_sent == items_accepted);
      for (n = 0; n < 20000 && expected_cells.size() > 0; n++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_cells.size() != 0) begin
         $error("%0d predicted cells never arrived", expected_cells.size());
         fail_count++;
      end

      $display("Run covered %0d tape updates and %0d cells over %0d register settings,",
               items_accepted, cells_checked, settings_run);
      $display("including clamped widths, wrapped columns and angles, and both stall cases.");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin : watchdog
      #20000000;
      $display("timeout with %0d cells still outstanding", expected_cells.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/otg_pkg.sv
hw/rtl/otg_ifs.sv
hw/rtl/otg_csr.sv
hw/rtl/otg_front.sv
hw/rtl/otg_emit.sv
hw/rtl/osd_compass_tape_glyphs_core.sv
hw/rtl/otg_chk.sv
verif/testbench.sv
